@@ rtl/mhbec_pkg.sv @@
// ----------------------------------------------------------------------------
// mhbec_pkg: shared definitions for the Manchester half-bit edge classifier
// Store sizes, gap thresholds, register indexes and the result record type.
// ----------------------------------------------------------------------------
package mhbec_pkg;

    // half-bit store
    localparam int HALF_BIT_DEPTH = 64;
    localparam int ADDR_W         = $clog2(HALF_BIT_DEPTH);
    localparam int CNT_W          = $clog2(HALF_BIT_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(HALF_BIT_DEPTH);

    // field widths
    localparam int GAP_W  = 16;
    localparam int IDX_W  = 7;
    localparam int CFG_AW = 2;

    // gap thresholds in us
    localparam logic [GAP_W-1:0] GAP_IGNORE = 16'd317;
    localparam logic [GAP_W-1:0] GAP_ONE    = 16'd517;
    localparam logic [GAP_W-1:0] GAP_GREY   = 16'd633;
    localparam logic [GAP_W-1:0] GAP_TWO    = 16'd1033;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_STOP_TIME = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PDOWN_TIME = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_INVERT    = 2'd2;

    // register reset values
    localparam logic [GAP_W-1:0] STOP_TIME_RST  = 16'd2400;
    localparam logic [GAP_W-1:0] PDOWN_TIME_RST = 16'd45000;

    // input kinds
    localparam logic KIND_EDGE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic             rec_valid;
        logic             rec_value;
        logic             rec_mid;
        logic [IDX_W-1:0] rec_index;
        logic             tim_err;
        logic             last;
    } t_result;

    typedef struct packed {
        logic             value;
        logic [GAP_W-1:0] gap;
    } t_half_bit;

endpackage

@@ rtl/manchester_half_bit_edge_classifier.sv @@
// ----------------------------------------------------------------------------
// manchester_half_bit_edge_classifier: Manchester half-bit edge classifier
// Classifies line edges by the gap since the previous edge and stores
// half-bit records for a Manchester frame decoder.
// ----------------------------------------------------------------------------
// Each input transfer is a line edge (with the us since the previous edge) or
// a frame restart. The edge is classified against the frame state in the same
// cycle it is taken, so a new edge may follow every cycle unless the input
// stalls. An edge that writes two half bits into the store stalls the input
// while its second record is pending, because the half-bit store has a single
// write port and takes the second record in the following cycle. Results
// leave through a four-entry queue, one per cycle unless stalled, so output
// stalls do not stall the input until the queue has less than two free
// entries. The first result shows in the cycle after the input transfer.
// Configuration is always ready; write it only while the block is idle. The
// half-bit store is not cleared at reset: its contents are undefined until
// written.
// ----------------------------------------------------------------------------
module manchester_half_bit_edge_classifier import mhbec_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_AW-1:0] i_cfg_index,
    input  logic [GAP_W-1:0]  i_cfg_data,
    // input channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_kind,
    input  logic              i_line_level,
    input  logic [GAP_W-1:0]  i_elapsed_us,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_record_valid,
    output logic              o_record_value,
    output logic              o_record_at_middle,
    output logic [IDX_W-1:0]  o_record_index,
    output logic              o_timing_error,
    output logic              o_last
);

    // configuration registers
    logic [GAP_W-1:0] r_stop_time;
    logic [GAP_W-1:0] r_pdown_time;
    logic             r_invert;

    // frame state
    logic             r_recv,  n_recv;
    logic             r_mid,   n_mid;
    logic [CNT_W-1:0] r_cnt,   n_cnt;

    // half-bit store (value and gap time), single write port
    t_half_bit        mem_hb [HALF_BIT_DEPTH];

    // second record of a two half-bit edge, written in the next cycle
    logic              r_pend;
    logic [ADDR_W-1:0] r_pend_addr;
    t_half_bit         r_pend_data;

    // result queue
    t_result           r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr;
    logic [FIFO_AW-1:0] r_rptr;
    logic [FIFO_CW-1:0] r_fcnt;

    // classification outputs
    t_result           w_res0;
    t_result           w_res1;
    logic              w_two;
    logic              w_wr0_en;
    logic [ADDR_W-1:0] w_wr0_addr;
    t_half_bit         w_wr0_data;
    logic              w_wr1_en;
    logic [ADDR_W-1:0] w_wr1_addr;
    t_half_bit         w_wr1_data;

    logic              w_edge;
    logic              w_long_err;
    logic              w_store0;
    logic              w_store1;
    logic [CNT_W-1:0]  w_cnt1;
    logic [CNT_W-1:0]  w_cnt2;
    logic              w_in_acc;
    logic              w_pop;
    logic [FIFO_CW-1:0] w_push_n;
    t_result           w_head;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    // need two free queue entries, and the store port must be free
    assign o_in_stall  = r_pend | (r_fcnt > FIFO_CW'(FIFO_DEPTH - 2));
    assign w_in_acc    = i_in_valid & ~o_in_stall;
    assign w_pop       = (r_fcnt != '0) & ~i_out_stall;

    // ------------------------------------------------------------------
    // Edge classification
    // ------------------------------------------------------------------
    // edge type: 1 rising, 0 falling
    assign w_edge     = i_line_level ^ r_invert;
    // long gap is legal only once the stop / power-down time has passed
    assign w_long_err = w_edge ? (i_elapsed_us < r_stop_time)
                               : (i_elapsed_us < r_pdown_time);

    // count after the first and second half bit (saturating at store size)
    assign w_store0 = r_cnt < DEPTH_C;
    assign w_cnt1   = r_cnt + CNT_W'(w_store0);
    assign w_store1 = w_cnt1 < DEPTH_C;
    assign w_cnt2   = w_cnt1 + CNT_W'(w_store1);

    always_comb begin
        n_recv     = r_recv;
        n_mid      = r_mid;
        n_cnt      = r_cnt;
        w_two      = 1'b0;

        // default: no record, current count, last
        w_res0           = '0;
        w_res0.rec_index = IDX_W'(r_cnt);
        w_res0.last      = 1'b1;
        w_res1           = '0;
        w_res1.rec_index = IDX_W'(r_cnt);
        w_res1.last      = 1'b1;

        w_wr0_en         = 1'b0;
        w_wr0_addr       = r_cnt[ADDR_W-1:0];
        w_wr0_data.value = w_edge;
        w_wr0_data.gap   = i_elapsed_us;
        w_wr1_en         = 1'b0;
        w_wr1_addr       = w_cnt1[ADDR_W-1:0];
        w_wr1_data.value = w_edge;
        w_wr1_data.gap   = i_elapsed_us;

        if (i_kind == KIND_RESTART) begin
            n_recv           = 1'b0;
            n_mid            = 1'b0;
            n_cnt            = '0;
            w_res0.rec_index = '0;
        end else if (!r_recv) begin
            // first edge of a frame opens a bit
            n_recv           = 1'b1;
            n_mid            = 1'b0;
            n_cnt            = w_cnt1;
            w_wr0_en         = w_store0;
            w_res0.rec_valid = w_store0;
            w_res0.rec_value = w_edge;
            w_res0.rec_index = IDX_W'(w_cnt1);
        end else if (i_elapsed_us <= GAP_IGNORE) begin
            // glitch, nothing to do
        end else if (!r_mid) begin
            if (i_elapsed_us < GAP_ONE) begin
                n_mid            = 1'b1;
                n_cnt            = w_cnt1;
                w_wr0_en         = w_store0;
                w_res0.rec_valid = w_store0;
                w_res0.rec_value = w_edge;
                w_res0.rec_mid   = 1'b1;
                w_res0.rec_index = IDX_W'(w_cnt1);
            end else begin
                w_res0.tim_err = w_long_err;
            end
        end else if (i_elapsed_us < GAP_ONE) begin
            n_mid            = 1'b0;
            n_cnt            = w_cnt1;
            w_wr0_en         = w_store0;
            w_res0.rec_valid = w_store0;
            w_res0.rec_value = w_edge;
            w_res0.rec_index = IDX_W'(w_cnt1);
        end else if (i_elapsed_us < GAP_GREY) begin
            w_res0.tim_err = 1'b1;
        end else if (i_elapsed_us < GAP_TWO) begin
            // two half bits: inserted bit start carries the line level
            w_two            = 1'b1;
            n_mid            = 1'b1;
            n_cnt            = w_cnt2;
            w_wr0_en         = w_store0;
            w_wr0_data.value = i_line_level;
            w_res0.rec_valid = w_store0;
            w_res0.rec_value = i_line_level;
            w_res0.rec_index = IDX_W'(w_cnt1);
            w_res0.last      = 1'b0;
            w_wr1_en         = w_store1;
            w_res1.rec_valid = w_store1;
            w_res1.rec_value = w_edge;
            w_res1.rec_mid   = 1'b1;
            w_res1.rec_index = IDX_W'(w_cnt2);
        end else begin
            w_res0.tim_err = w_long_err;
        end
    end

    // ------------------------------------------------------------------
    // Configuration and frame state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_time  <= STOP_TIME_RST;
            r_pdown_time <= PDOWN_TIME_RST;
            r_invert     <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STOP_TIME:  r_stop_time  <= i_cfg_data;
                CFG_PDOWN_TIME: r_pdown_time <= i_cfg_data;
                CFG_INVERT:     r_invert     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recv <= 1'b0;
            r_mid  <= 1'b0;
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_recv <= n_recv;
                r_mid  <= n_mid;
                r_cnt  <= n_cnt;
            end
            r_pend <= w_in_acc & w_two & w_wr1_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pend_addr <= w_wr1_addr;
            r_pend_data <= w_wr1_data;
        end
    end

    // ------------------------------------------------------------------
    // Half-bit store: one write per cycle; input is held while a second
    // record is pending, so the two sources never collide
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_wr0_en) begin
            mem_hb[w_wr0_addr] <= w_wr0_data;
        end else if (r_pend) begin
            mem_hb[r_pend_addr] <= r_pend_data;
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    assign w_push_n = w_in_acc ? (w_two ? FIFO_CW'(2) : FIFO_CW'(1)) : '0;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_fifo[r_wptr] <= w_res0;
            if (w_two) begin
                r_fifo[r_wptr + FIFO_AW'(1)] <= w_res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fcnt <= '0;
        end else begin
            r_wptr <= r_wptr + w_push_n[FIFO_AW-1:0];
            r_rptr <= r_rptr + FIFO_AW'(w_pop);
            r_fcnt <= r_fcnt + w_push_n - FIFO_CW'(w_pop);
        end
    end

    assign w_head             = r_fifo[r_rptr];
    assign o_out_valid        = r_fcnt != '0;
    assign o_record_valid     = w_head.rec_valid;
    assign o_record_value     = w_head.rec_value;
    assign o_record_at_middle = w_head.rec_mid;
    assign o_record_index     = w_head.rec_index;
    assign o_timing_error     = w_head.tim_err;
    assign o_last             = w_head.last;

endmodule

@@ rtl/mhbec_checker.sv @@
// ----------------------------------------------------------------------------
// mhbec_props: port-level checks for the half-bit edge classifier
// Watches the top-level ports and flags ordering and latency slips.
// ----------------------------------------------------------------------------
module mhbec_props import mhbec_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              i_kind,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_record_valid,
    input logic              o_record_value,
    input logic              o_record_at_middle,
    input logic [IDX_W-1:0]  o_record_index,
    input logic              o_timing_error,
    input logic              o_last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_record_valid)
            && $stable(o_record_value) && $stable(o_record_at_middle)
            && $stable(o_record_index) && $stable(o_timing_error) && $stable(o_last))
        else $error("result changed while stalled");

    // every input transfer yields a result in the next cycle
    a_in_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("no result after input transfer");

    // restart into an empty queue: next result is an empty last record
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_kind && !o_out_valid
            |=> o_out_valid && !o_record_valid && o_last && (o_record_index == '0)
                && !o_timing_error)
        else $error("bad restart result");

    // the second half of a two-record item is already queued
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && !i_out_stall |=> o_out_valid && o_last
            && o_record_at_middle)
        else $error("missing second half-bit result");

endmodule

bind manchester_half_bit_edge_classifier mhbec_props u_mhbec_props (.*);

@@ test/mhbec_checker.sv @@
// ----------------------------------------------------------------------------
// mhbec_checker: result checker for the Manchester half-bit edge classifier
// Watches the configuration, edge and result channels and keeps a shadow
// copy of the frame state. Each result is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module mhbec_checker import mhbec_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CFG_AW-1:0] i_cfg_index,
    input  logic [GAP_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_kind,
    input  logic              i_line_level,
    input  logic [GAP_W-1:0]  i_elapsed_us,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic              i_record_valid,
    input  logic              i_record_value,
    input  logic              i_record_at_middle,
    input  logic [IDX_W-1:0]  i_record_index,
    input  logic              i_timing_error,
    input  logic              i_last,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow registers
    logic [GAP_W-1:0] stop_us;
    logic [GAP_W-1:0] pdown_us;
    logic             invert;

    // shadow frame state
    logic             rx_active;
    logic             pos_middle;
    int unsigned      half_bits;

    t_result expected_results[$];

    function automatic void push_result(input logic valid, input logic value,
                                        input logic mid, input logic err,
                                        input logic last);
        t_result r;
        r.rec_valid = valid;
        r.rec_value = value;
        r.rec_mid   = mid;
        r.rec_index = IDX_W'(half_bits);
        r.tim_err   = err;
        r.last      = last;
        expected_results.push_back(r);
    endfunction

    // move to a position, store one half bit if there is room
    function automatic logic take_half_bit(input logic mid);
        pos_middle = mid;
        if (half_bits < HALF_BIT_DEPTH) begin
            half_bits++;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic long_gap_fault(input logic rising, input logic [GAP_W-1:0] gap);
        return rising ? (gap < stop_us) : (gap < pdown_us);
    endfunction

    function automatic void classify_edge(input logic kind, input logic level,
                                          input logic [GAP_W-1:0] gap);
        logic rising;
        logic stored;
        rising = level ^ invert;
        if (kind == KIND_RESTART) begin
            half_bits  = 0;
            pos_middle = 1'b0;
            rx_active  = 1'b0;
            push_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        end else if (!rx_active) begin
            // first edge of a frame opens a bit
            rx_active = 1'b1;
            stored = take_half_bit(1'b0);
            push_result(stored, rising, 1'b0, 1'b0, 1'b1);
        end else if (gap <= GAP_IGNORE) begin
            push_result(1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        end else if (!pos_middle) begin
            if (gap < GAP_ONE) begin
                stored = take_half_bit(1'b1);
                push_result(stored, rising, 1'b1, 1'b0, 1'b1);
            end else begin
                push_result(1'b0, 1'b0, 1'b0, long_gap_fault(rising, gap), 1'b1);
            end
        end else if (gap < GAP_ONE) begin
            stored = take_half_bit(1'b0);
            push_result(stored, rising, 1'b0, 1'b0, 1'b1);
        end else if (gap < GAP_GREY) begin
            push_result(1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        end else if (gap < GAP_TWO) begin
            // inserted half bit carries the raw line level
            stored = take_half_bit(1'b0);
            push_result(stored, level, 1'b0, 1'b0, 1'b0);
            stored = take_half_bit(1'b1);
            push_result(stored, rising, 1'b1, 1'b0, 1'b1);
        end else begin
            push_result(1'b0, 1'b0, 1'b0, long_gap_fault(rising, gap), 1'b1);
        end
    endfunction

    function automatic void report_failure(input string what, input t_result exp,
                                           input t_result got);
        o_fail_count++;
        if (o_fail_count <= 10)
            $display("%0t ERROR %s: exp v=%b val=%b mid=%b idx=%0d err=%b last=%b | got v=%b val=%b mid=%b idx=%0d err=%b last=%b",
                     $realtime, what,
                     exp.rec_valid, exp.rec_value, exp.rec_mid, exp.rec_index,
                     exp.tim_err, exp.last,
                     got.rec_valid, got.rec_value, got.rec_mid, got.rec_index,
                     got.tim_err, got.last);
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result exp;
        if (!i_rst_n) begin
            stop_us      = STOP_TIME_RST;
            pdown_us     = PDOWN_TIME_RST;
            invert       = 1'b0;
            rx_active    = 1'b0;
            pos_middle   = 1'b0;
            half_bits    = 0;
            o_fail_count = 0;
            o_checked    = 0;
            expected_results.delete();
        end else begin
            // results first: a result never stems from the same-edge input transfer
            if (i_out_valid && !i_out_stall) begin
                got.rec_valid = i_record_valid;
                got.rec_value = i_record_value;
                got.rec_mid   = i_record_at_middle;
                got.rec_index = i_record_index;
                got.tim_err   = i_timing_error;
                got.last      = i_last;
                if (expected_results.size() == 0) begin
                    exp = '0;
                    report_failure("unexpected result", exp, got);
                end else begin
                    exp = expected_results.pop_front();
                    o_checked++;
                    if (got !== exp)
                        report_failure("result mismatch", exp, got);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_STOP_TIME:  stop_us  = i_cfg_data;
                    CFG_PDOWN_TIME: pdown_us = i_cfg_data;
                    CFG_INVERT:     invert   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                classify_edge(i_kind, i_line_level, i_elapsed_us);
        end
        o_pending = expected_results.size();
    end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for the Manchester half-bit edge classifier
// Drives directed and random Manchester frames under several register
// settings and idle mixes; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top import mhbec_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    // gap classes for random frames
    typedef enum {
        CLS_HALF,       // one half bit
        CLS_DOUBLE,     // two half bits
        CLS_IGNORE,     // glitch, dropped
        CLS_GREY,       // between one and two half bits
        CLS_LONG,       // stop / power-down check
        CLS_BOUNDARY,   // right at a configured idle time
        CLS_NOISE       // anything
    } t_gap_class;

    localparam int RANDOM_ITEMS = 1800;
    localparam int N_SETTINGS   = 6;
    localparam int HOLD_CYCLES  = 400;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CFG_AW-1:0] i_cfg_index;
    logic [GAP_W-1:0]  i_cfg_data;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_kind;
    logic              i_line_level;
    logic [GAP_W-1:0]  i_elapsed_us;
    logic              o_out_valid;
    logic              i_out_stall;
    logic              o_record_valid;
    logic              o_record_value;
    logic              o_record_at_middle;
    logic [IDX_W-1:0]  o_record_index;
    logic              o_timing_error;
    logic              o_last;

    int fail_count;
    int pending;
    int checked;

    // idle mix, in percent per cycle
    int send_idle_pct;
    int recv_idle_pct;

    // long receiver hold-off: top bumps the request count, receiver serves it
    int hold_requests;

    // the top's own view of the registers, for boundary gaps
    logic [GAP_W-1:0] stop_cfg;
    logic [GAP_W-1:0] pdown_cfg;

    int items_sent;
    int settings_used;

    manchester_half_bit_edge_classifier DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_line_level       (i_line_level),
        .i_elapsed_us       (i_elapsed_us),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_record_valid     (o_record_valid),
        .o_record_value     (o_record_value),
        .o_record_at_middle (o_record_at_middle),
        .o_record_index     (o_record_index),
        .o_timing_error     (o_timing_error),
        .o_last             (o_last)
    );

    mhbec_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_line_level       (i_line_level),
        .i_elapsed_us       (i_elapsed_us),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_record_valid     (o_record_valid),
        .i_record_value     (o_record_value),
        .i_record_at_middle (o_record_at_middle),
        .i_record_index     (o_record_index),
        .i_timing_error     (o_timing_error),
        .i_last             (o_last),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_checked          (checked)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // run limit: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("TIMEOUT: %0d results still outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

    // receiver: random stall at the falling edge, or a long hold-off on request
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // one input transfer; called at a falling edge, returns at a falling edge
    // with valid still high so back-to-back transfers never drop it
    task automatic send_item(input logic kind, input logic level,
                             input logic [GAP_W-1:0] gap);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_line_level <= level;
        i_elapsed_us <= gap;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_edge(input logic level, input int gap);
        send_item(KIND_EDGE, level, GAP_W'(gap));
    endtask

    task automatic send_restart();
        send_item(KIND_RESTART, 1'($urandom), GAP_W'($urandom));
    endtask

    // wait until every expected result has been checked, then settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [GAP_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_setting(input logic [GAP_W-1:0] stop_us,
                                 input logic [GAP_W-1:0] pdown_us, input logic inv);
        logic [GAP_W-1:0] inv_word;
        wait_idle();
        // upper bits of the polarity word must be ignored
        inv_word = GAP_W'($urandom);
        inv_word[0] = inv;
        write_reg(CFG_STOP_TIME, stop_us);
        write_reg(CFG_PDOWN_TIME, pdown_us);
        write_reg(CFG_INVERT, inv_word);
        stop_cfg  = stop_us;
        pdown_cfg = pdown_us;
        settings_used++;
    endtask

    function automatic t_gap_class pick_class();
        int r;
        r = $urandom_range(99);
        if (r < 55) return CLS_HALF;
        if (r < 75) return CLS_DOUBLE;
        if (r < 81) return CLS_IGNORE;
        if (r < 86) return CLS_GREY;
        if (r < 92) return CLS_LONG;
        if (r < 96) return CLS_BOUNDARY;
        return CLS_NOISE;
    endfunction

    function automatic int pick_gap(input t_gap_class cls);
        int t;
        case (cls)
            CLS_HALF:   return $urandom_range(516, 318);
            CLS_DOUBLE: return $urandom_range(1032, 633);
            CLS_IGNORE: return $urandom_range(317, 0);
            CLS_GREY:   return $urandom_range(632, 517);
            CLS_LONG:   return $urandom_range(65535, 1033);
            CLS_BOUNDARY: begin
                // one below, at, or one above an idle time
                t = $urandom_range(1) ? int'(stop_cfg) : int'(pdown_cfg);
                t = t + $urandom_range(2) - 1;
                if (t < 0) t = 0;
                if (t > 65535) t = 65535;
                return t;
            end
            default:    return $urandom_range(65535);
        endcase
    endfunction

    // a frame: optional restart, an opening edge, then mostly legal gaps
    task automatic send_frame(input int n_edges);
        int k;
        if ($urandom_range(3) != 0)
            send_restart();
        send_edge(1'($urandom), $urandom_range(65535));
        for (k = 0; k < n_edges; k++) begin
            if ($urandom_range(99) < 2)
                send_restart();
            else
                send_edge(1'($urandom), pick_gap(pick_class()));
        end
    endtask

    task automatic run_random(input int budget);
        int stop_at;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            // a few long frames overflow the 64-entry store
            if ($urandom_range(9) == 0)
                send_frame($urandom_range(90, 60));
            else
                send_frame($urandom_range(40, 3));
        end
    endtask

    initial begin : stimulus
        int s;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_EDGE;
        i_line_level  = 1'b0;
        i_elapsed_us  = '0;
        send_idle_pct = 15;
        recv_idle_pct = 58;
        hold_requests = 0;
        stop_cfg      = STOP_TIME_RST;
        pdown_cfg     = PDOWN_TIME_RST;
        items_sent    = 0;
        settings_used = 1;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed walk through the classification, reset register values
        send_restart();
        send_edge(1'b1, 65535);     // opening edge, largest gap
        send_edge(1'b0, 0);         // glitch
        send_edge(1'b1, 317);       // largest ignored gap
        send_edge(1'b0, 318);       // to middle
        send_edge(1'b1, 318);       // to start
        send_edge(1'b0, 516);       // to middle
        send_edge(1'b1, 517);       // grey zone low end
        send_edge(1'b0, 632);       // grey zone high end
        send_edge(1'b1, 633);       // double half bit, low end
        send_edge(1'b0, 1032);      // double half bit, high end
        send_edge(1'b1, 1033);      // rising before stop time
        send_edge(1'b1, 2399);
        send_edge(1'b1, 2400);      // stop time reached
        send_edge(1'b0, 44999);     // falling before power down
        send_edge(1'b0, 45000);     // power down reached
        send_edge(1'b0, 516);       // from middle back to start
        send_edge(1'b1, 517);       // long-gap check from bit start
        send_edge(1'b0, 516);       // to middle
        send_edge(1'b0, 1033);
        send_item(KIND_RESTART, 1'b1, 16'hFFFF);
        send_edge(1'b0, 400);       // new frame opens on a falling edge

        // random phases; idle mix moves from sender-light to receiver-light to none
        for (s = 0; s < N_SETTINGS; s++) begin
            case (s)
                0: apply_setting(16'd0, 16'd0, 1'b0);
                1: apply_setting(16'hFFFF, 16'hFFFF, 1'b1);
                2: apply_setting(GAP_W'($urandom), GAP_W'($urandom), 1'b1);
                3: apply_setting(STOP_TIME_RST, PDOWN_TIME_RST, 1'b0);
                4: apply_setting(GAP_W'($urandom_range(5000, 1033)),
                                 GAP_W'($urandom), 1'b0);
                default: apply_setting(GAP_W'($urandom), GAP_W'($urandom), 1'b1);
            endcase
            if (s == 2) begin
                send_idle_pct = 58;
                recv_idle_pct = 15;
            end else if (s == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                // receiver stops while edges keep coming: queue fills, input stalls
                hold_requests++;
            end
            run_random(RANDOM_ITEMS / N_SETTINGS);
        end

        // drain, then watch for stray results
        wait_idle();
        repeat (20) @(negedge i_clk);

        $display("Covered %0d input transfers under %0d register settings, %0d results compared",
                 items_sent, settings_used, checked);
        $display("Idle mixes 15/58, 58/15 and none, plus one long receiver hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
